@@ rtl/core/slfr_pkg.sv @@
package slfr_pkg;

  localparam int WORD_W = 30;
  localparam int SEED_W = 32;

  localparam logic [SEED_W-1:0] MODULUS = 32'd1000000000;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SEED_W-1:0] seed_t;

  // (a - b) mod 10^9; adds the modulus back when a < b, then keeps 30 bits
  function automatic word_t sub_mod(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    if (a < b) begin
      s = {1'b0, a} + MODULUS[WORD_W:0] - {1'b0, b};
    end else begin
      s = {1'b0, a} - {1'b0, b};
    end
    return s[WORD_W-1:0];
  endfunction

endpackage

@@ rtl/core/slfr_ram.sv @@
module slfr_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 55
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                        rdata_a,
  output logic [WIDTH-1:0]                        rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/core/subtractive_lagged_fibonacci_rng.sv @@
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+------------------------------
// request  | in_req_type, in_seed_value              | taken when start && !busy
// result   | out_random_value                        | out_valid, one-cycle strobe
//
// Draw: busy in ST_READ (ring read), then ST_WRITE (subtract and write back);
// the value shows on the result ports, with out_valid, in the cycle after that.
// Seed: compare/subtract reduction of 10^9 until below it, LONG_LAG-1 fill
// writes, then WARMUP_ROUNDS*LONG_LAG warm-up draws, each a ring read and write back.
// Reset and every seed clear the per-entry valid bits at once, so the ring
// reads as all zeros until written. The receiver cannot stall a result beat.
module subtractive_lagged_fibonacci_rng #(
  parameter int LONG_LAG      = 55,
  parameter int SHORT_LAG     = 24,
  parameter int SPREAD_STEP   = 21,
  parameter int WARMUP_ROUNDS = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  slfr_pkg::seed_t       in_seed_value,
  output logic                  out_valid,
  output slfr_pkg::word_t       out_random_value
);

  import slfr_pkg::*;

  // ring position width
  localparam int PW = $clog2(LONG_LAG);
  localparam logic [PW-1:0] SHORT_START =
    PW'((LONG_LAG - (SHORT_LAG % LONG_LAG)) % LONG_LAG);
  localparam logic [PW:0] STEP_MOD = (PW+1)'(SPREAD_STEP % LONG_LAG);
  localparam logic [PW:0] LAG_EXT  = (PW+1)'(LONG_LAG);
  localparam logic [PW-1:0] LAST_POS = PW'(LONG_LAG - 1);

  // warm-up draw count
  localparam int WARM_N = WARMUP_ROUNDS * LONG_LAG;
  localparam int WCW    = (WARM_N > 0) ? $clog2(WARM_N + 1) : 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_WRITE  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [PW-1:0]       oldest_r, oldest_nxt;
  logic [PW-1:0]       short_r, short_nxt;
  logic [LONG_LAG-1:0] vld_r, vld_nxt;
  logic                vld_a_r, vld_b_r;
  logic                warm_r, warm_nxt;
  logic [WCW-1:0]      warm_cnt_r, warm_cnt_nxt;
  seed_t               seed_r, seed_nxt;
  word_t               prev_r, prev_nxt;
  word_t               next_r, next_nxt;
  logic [PW-1:0]       slot_r, slot_nxt;
  logic [PW-1:0]       fill_cnt_r, fill_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  word_t               out_value_r, out_value_nxt;

  // ring port signals
  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  word_t               ram_wdata;
  logic                ram_re;
  word_t               ram_rdata_a, ram_rdata_b;
  word_t               op_a, op_b, diff;
  logic [PW:0]         slot_sum;

  slfr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LONG_LAG)
  ) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (oldest_r),
    .raddr_b (short_r),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // entries never written since reset or seed read as zero
  assign op_a     = vld_a_r ? ram_rdata_a : '0;
  assign op_b     = vld_b_r ? ram_rdata_b : '0;
  assign diff     = sub_mod(op_a, op_b);
  assign slot_sum = {1'b0, slot_r} + STEP_MOD;
  assign ram_re   = (state_r == ST_READ);

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    short_nxt     = short_r;
    vld_nxt       = vld_r;
    warm_nxt      = warm_r;
    warm_cnt_nxt  = warm_cnt_r;
    seed_nxt      = seed_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    slot_nxt      = slot_r;
    fill_cnt_nxt  = fill_cnt_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    ram_we        = 1'b0;
    ram_waddr     = oldest_r;
    ram_wdata     = diff;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_req_type == REQ_SEED) begin
            seed_nxt   = in_seed_value;
            vld_nxt    = '0;
            oldest_nxt = '0;
            short_nxt  = SHORT_START;
            state_nxt  = ST_REDUCE;
          end else begin
            warm_nxt  = 1'b0;
            state_nxt = ST_READ;
          end
        end
      end

      // at most four subtractions bring a 32-bit seed below 10^9
      ST_REDUCE: begin
        if (seed_r >= MODULUS) begin
          seed_nxt = seed_r - MODULUS;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = '0;
          ram_wdata    = seed_r[WORD_W-1:0];
          vld_nxt[0]   = 1'b1;
          prev_nxt     = seed_r[WORD_W-1:0];
          next_nxt     = word_t'(1);
          slot_nxt     = STEP_MOD[PW-1:0];
          fill_cnt_nxt = PW'(1);
          state_nxt    = ST_FILL;
        end
      end

      // spread fill: slot steps by SPREAD_STEP mod LONG_LAG
      ST_FILL: begin
        ram_we          = 1'b1;
        ram_waddr       = slot_r;
        ram_wdata       = next_r;
        vld_nxt[slot_r] = 1'b1;
        next_nxt        = sub_mod(prev_r, next_r);
        prev_nxt        = next_r;
        slot_nxt        = (slot_sum >= LAG_EXT) ? PW'(slot_sum - LAG_EXT) : slot_sum[PW-1:0];
        fill_cnt_nxt    = fill_cnt_r + PW'(1);
        if (fill_cnt_r == LAST_POS) begin
          warm_nxt     = 1'b1;
          warm_cnt_nxt = WCW'(WARM_N);
          state_nxt    = (WARM_N > 0) ? ST_READ : ST_IDLE;
        end
      end

      ST_READ: begin
        state_nxt = ST_WRITE;
      end

      ST_WRITE: begin
        ram_we            = 1'b1;
        vld_nxt[oldest_r] = 1'b1;
        oldest_nxt        = (oldest_r == LAST_POS) ? '0 : oldest_r + PW'(1);
        short_nxt         = (short_r == LAST_POS) ? '0 : short_r + PW'(1);
        if (warm_r) begin
          warm_cnt_nxt = warm_cnt_r - WCW'(1);
          state_nxt    = (warm_cnt_r == WCW'(1)) ? ST_IDLE : ST_READ;
        end else begin
          out_valid_nxt = 1'b1;
          out_value_nxt = diff;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      short_r     <= SHORT_START;
      vld_r       <= '0;
      warm_r      <= 1'b0;
      warm_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      short_r     <= short_nxt;
      vld_r       <= vld_nxt;
      warm_r      <= warm_nxt;
      warm_cnt_r  <= warm_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    seed_r      <= seed_nxt;
    prev_r      <= prev_nxt;
    next_r      <= next_nxt;
    slot_r      <= slot_nxt;
    fill_cnt_r  <= fill_cnt_nxt;
    out_value_r <= out_value_nxt;
    if (ram_re) begin
      vld_a_r <= vld_r[oldest_r];
      vld_b_r <= vld_r[short_r];
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import slfr_pkg::*;

  // Generator geometry, matching the block's default parameters
  localparam int RING_LEN = 55;   // long lag
  localparam int TAP_LAG  = 24;   // short lag
  localparam int SPREAD   = 21;   // fill stride through the ring
  localparam int WARMUP   = 5;    // silent passes over the ring per seed

  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM   = 550;
  localparam int N_PHASES   = 4;
  // Tail wait after the last drain, longer than the worst seed's busy time
  localparam int DRAIN_CYCLES = 620;

  typedef struct {
    logic  req;
    seed_t seed;
    bit    fixed;     // expected value typed into the row
    word_t fixed_val;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  logic  in_req_type = REQ_DRAW;
  seed_t in_seed_value = '0;
  logic  out_valid;
  word_t out_random_value;

  // Side-band that travels with each driven beat: a literal expectation
  bit    lit_on = 1'b0;
  word_t lit_word = '0;

  // Predictor state: own copy of the lag ring and its two read positions
  word_t       value_ring [RING_LEN];
  int unsigned head_pos;   // oldest word, overwritten by each draw
  int unsigned tap_pos;    // word TAP_LAG steps back

  word_t pending_values[$];   // expected draw results, oldest first
  int    n_errors = 0;
  int    n_seeds = 0;
  int    n_draws = 0;
  int    n_checked = 0;

  stim_row_t dir_tab [N_DIRECTED];
  int        idle_pct [N_PHASES];

  always #6 clk = ~clk;

  subtractive_lagged_fibonacci_rng uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_random_value (out_random_value)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void ring_clear();
    foreach (value_ring[k]) value_ring[k] = '0;
    head_pos = 0;
    tap_pos  = RING_LEN - TAP_LAG;
  endfunction

  // One step of the subtractive recurrence: X[n] = X[n-55] - X[n-24] mod 10^9,
  // written back over X[n-55].
  function automatic word_t ring_advance();
    word_t       x;
    word_t       y;
    word_t       d;
    logic [31:0] wide;
    x = value_ring[head_pos];
    y = value_ring[tap_pos];
    if (x < y) begin
      wide = {2'b00, x} + MODULUS - {2'b00, y};
      d = wide[WORD_W-1:0];
    end else begin
      d = x - y;
    end
    value_ring[head_pos] = d;
    head_pos = (head_pos + 1) % RING_LEN;
    tap_pos  = (tap_pos + 1) % RING_LEN;
    return d;
  endfunction

  // Reseed: clear, reduce, spread-fill the ring, then burn the warm-up draws
  function automatic void ring_reseed(input seed_t s);
    word_t       prev;
    word_t       nxt;
    int unsigned slot;
    int unsigned i;
    logic [31:0] wide;
    ring_clear();
    prev = word_t'(s % MODULUS);
    value_ring[0] = prev;
    nxt = 1;
    for (i = 1; i < RING_LEN; i++) begin
      slot = (SPREAD * i) % RING_LEN;
      value_ring[slot] = nxt;
      if (prev < nxt) begin
        wide = {2'b00, prev} + MODULUS - {2'b00, nxt};
        nxt = wide[WORD_W-1:0];
      end else begin
        nxt = prev - nxt;
      end
      prev = value_ring[slot];
    end
    repeat (WARMUP * RING_LEN) void'(ring_advance());
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: both sample at the rising edge, before the block's registers move
  // ---------------------------------------------------------------------------

  // Request side: every accepted beat updates the predictor
  always @(posedge clk) begin
    word_t v;
    if (rst_n && start && !busy) begin
      if (in_req_type == REQ_SEED) begin
        ring_reseed(in_seed_value);
        n_seeds++;
      end else begin
        v = ring_advance();
        pending_values.push_back(lit_on ? lit_word : v);
        n_draws++;
      end
    end
  end

  // Result side: a strobe cannot be held off, so every one is checked
  always @(posedge clk) begin
    word_t exp_v;
    if (rst_n && out_valid) begin
      if (pending_values.size() == 0) begin
        $error("random_value: result beat with nothing expected, got %0d",
               out_random_value);
        n_errors++;
      end else begin
        exp_v = pending_values.pop_front();
        n_checked++;
        if (out_random_value !== exp_v) begin
          $error("random_value: expected %0d, got %0d", exp_v, out_random_value);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // Present one request beat at the falling edge, after a random idle gap, and
  // return at the rising edge that takes it. start stays high into the next
  // beat when there is no gap.
  task automatic send_beat(input logic req, input seed_t sv, input bit has_lit,
                           input word_t lit, input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    in_req_type   <= req;
    in_seed_value <= sv;
    lit_on        <= has_lit;
    lit_word      <= lit;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and hold off until every outstanding draw has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  // Random seed word: full-range a quarter of the time, otherwise near the modulus
  // or near the top of the 32-bit range where the reduction matters
  function automatic seed_t pick_seed();
    case ($urandom_range(3))
      0:       return MODULUS - 1 - $urandom_range(15);
      1:       return MODULUS + $urandom_range(15);
      2:       return 32'hFFFF_FFFF - $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int    p;
    int    k;
    int    per_phase;
    seed_t s;

    ring_clear();

    // Directed rows. Draws before any seed read an all-zero ring, so their
    // value is typed in; everything else goes through the predictor.
    dir_tab[0]  = '{REQ_DRAW, 32'd0,          1'b1, 30'd0};
    dir_tab[1]  = '{REQ_DRAW, 32'hFFFF_FFFF,  1'b1, 30'd0};
    dir_tab[2]  = '{REQ_DRAW, 32'd0,          1'b1, 30'd0};
    dir_tab[3]  = '{REQ_SEED, 32'd0,          1'b0, 30'd0};
    dir_tab[4]  = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[5]  = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[6]  = '{REQ_SEED, 32'hFFFF_FFFF,  1'b0, 30'd0};  // above modulus
    dir_tab[7]  = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[8]  = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[9]  = '{REQ_SEED, 32'd999999999,  1'b0, 30'd0};  // largest kept as is
    dir_tab[10] = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[11] = '{REQ_SEED, 32'd1000000000, 1'b0, 30'd0};  // reduces to zero
    dir_tab[12] = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[13] = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[14] = '{REQ_SEED, 32'd1,          1'b0, 30'd0};
    dir_tab[15] = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[16] = '{REQ_SEED, 32'd161803398,  1'b0, 30'd0};
    dir_tab[17] = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[18] = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[19] = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};
    dir_tab[20] = '{REQ_SEED, 32'h8000_0000,  1'b0, 30'd0};
    dir_tab[21] = '{REQ_DRAW, 32'd0,          1'b0, 30'd0};

    // Sender idle rates per random phase. The third phase stands for receiver
    // stalls, which this interface has no way to apply, so it runs flat out.
    idle_pct[0] = 0;
    idle_pct[1] = 51;
    idle_pct[2] = 0;
    idle_pct[3] = 19;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_DIRECTED; k++) begin
      send_beat(dir_tab[k].req, dir_tab[k].seed, dir_tab[k].fixed,
                dir_tab[k].fixed_val, 0);
    end
    drain_results();

    // Random part: runs of draws broken by occasional reseeds, about one beat in
    // twenty.
    per_phase = N_RANDOM / N_PHASES;
    for (p = 0; p < N_PHASES; p++) begin
      for (k = 0; k < per_phase; k++) begin
        if ($urandom_range(99) < 5) begin
          s = pick_seed();
          send_beat(REQ_SEED, s, 1'b0, '0, idle_pct[p]);
        end else begin
          // seed field is don't-care on draws; keep it toggling anyway
          send_beat(REQ_DRAW, $urandom, 1'b0, '0, idle_pct[p]);
        end
      end
      // Full stop between phases: nothing in flight before the next one
      drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d seed and %0d draw beats; %0d values checked, %0d errors",
             n_seeds, n_draws, n_checked, n_errors);
    if (n_errors == 0 && pending_values.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every beat a full reseed)
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
